// ===== rtl/logistic_nesterov_update_core_macros.svh =====
// Assertion macros shared by the logistic Nesterov update core.
`ifndef LOGISTIC_NESTEROV_UPDATE_CORE_MACROS_SVH
`define LOGISTIC_NESTEROV_UPDATE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LNU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define LNU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/lnu_pkg.sv =====
// Package with types, codes and fixed-point helpers for the update core.
`timescale 1ns / 1ps
package lnu_pkg;
  localparam int MAX_FEATURES_DEF = 64;
  localparam int QW = 32;
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [2:0] REG_GAMMA = 3'd0;
  localparam logic [2:0] REG_C0    = 3'd1;
  localparam logic [2:0] REG_C1    = 3'd2;
  localparam logic [2:0] REG_C3    = 3'd3;
  localparam logic [2:0] REG_COUNT = 3'd4;

  typedef logic signed [31:0] q_t;

  function automatic q_t sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rounded Q8.24 product, not yet saturated (>>> is a floor shift).
  function automatic logic signed [63:0] qmul_wide(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + 64'sd8388608;
    return p >>> 24;
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    return sat64(qmul_wide(a, b));
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat64(64'(a) + 64'(b));
  endfunction
endpackage

// ===== rtl/lnu_if.sv =====
// Valid/ready stream interface carrying a parameterized payload.
`timescale 1ns / 1ps
interface lnu_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lnu_regs.sv =====
// APB-style configuration register file.
`timescale 1ns / 1ps
module lnu_regs #(
  parameter int MAX_FEATURES = lnu_pkg::MAX_FEATURES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output lnu_pkg::q_t                  gamma_scale,
  output lnu_pkg::q_t                  coef_zero,
  output lnu_pkg::q_t                  coef_one,
  output lnu_pkg::q_t                  coef_three,
  output logic [$clog2(MAX_FEATURES+1)-1:0] used_count
);
  localparam int CW = $clog2(MAX_FEATURES + 1);
  logic [6:0] feature_count;
  logic [2:0] sel;
  assign sel = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_scale <= '0;
      coef_zero <= '0;
      coef_one <= '0;
      coef_three <= '0;
      feature_count <= 7'd64;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        lnu_pkg::REG_GAMMA: gamma_scale <= pwdata;
        lnu_pkg::REG_C0:    coef_zero <= pwdata;
        lnu_pkg::REG_C1:    coef_one <= pwdata;
        lnu_pkg::REG_C3:    coef_three <= pwdata;
        lnu_pkg::REG_COUNT: feature_count <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      lnu_pkg::REG_GAMMA: prdata = gamma_scale;
      lnu_pkg::REG_C0:    prdata = coef_zero;
      lnu_pkg::REG_C1:    prdata = coef_one;
      lnu_pkg::REG_C3:    prdata = coef_three;
      lnu_pkg::REG_COUNT: prdata = {25'd0, feature_count};
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    if (feature_count == 7'd0) used_count = CW'(1);
    else if (int'(feature_count) > MAX_FEATURES) used_count = CW'(MAX_FEATURES);
    else used_count = CW'(feature_count);
  end
endmodule

// ===== rtl/lnu_engine.sv =====
// Sequencer and memories for row loading, gradient accumulation and update.
`timescale 1ns / 1ps
`include "logistic_nesterov_update_core_macros.svh"
module lnu_engine #(
  parameter int MAX_FEATURES = lnu_pkg::MAX_FEATURES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lnu_pkg::q_t          gamma_scale,
  input  lnu_pkg::q_t          coef_zero,
  input  lnu_pkg::q_t          coef_one,
  input  lnu_pkg::q_t          coef_three,
  input  logic [$clog2(MAX_FEATURES+1)-1:0] used_count,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [5:0]           in_index,
  input  lnu_pkg::q_t          in_feature,
  input  lnu_pkg::q_t          in_eta,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [5:0]           out_index,
  output lnu_pkg::q_t          out_weight,
  output logic                 out_last
);
  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW = $clog2(MAX_FEATURES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DOT, S_DOTW, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
    S_GRD, S_UPD, S_UPD2, S_UPD3, S_OUT, S_CLR
  } state_t;

  // Memories: row, gradient, and a combined weight/momentum word.
  lnu_pkg::q_t row_mem [MAX_FEATURES];
  lnu_pkg::q_t grad_mem [MAX_FEATURES];
  logic [63:0] wm_mem [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] grad_ok, wm_ok;

  state_t state;
  logic [AW-1:0] ra, la;
  logic [CW-1:0] cnt;
  lnu_pkg::q_t row_q, grad_q;
  logic [63:0] wm_q;
  logic grad_ok_q, wm_ok_q;
  logic signed [63:0] acc;
  lnu_pkg::q_t ip, t2, tmp, eta, onem, t1, t2u;
  lnu_pkg::q_t m_a, m_b;
  logic rd_en;

  logic signed [63:0] m_wide;
  assign m_wide = lnu_pkg::qmul_wide(m_a, m_b);

  assign in_ready = (state == S_IDLE) && !out_valid;
  logic acc_in;
  assign acc_in = in_valid && in_ready;

  lnu_pkg::q_t grad_val, w_val, m_val;
  assign grad_val = grad_ok_q ? grad_q : '0;
  assign w_val = wm_ok_q ? wm_q[63:32] : '0;
  assign m_val = wm_ok_q ? wm_q[31:0] : '0;

  // Read port, one address per cycle, registered data.
  always_ff @(posedge clk) begin
    row_q <= row_mem[ra];
    grad_q <= grad_mem[ra];
    wm_q <= wm_mem[ra];
    grad_ok_q <= grad_ok[ra];
    wm_ok_q <= wm_ok[ra];
    la <= ra;
    rd_en <= (state == S_DOT) || (state == S_GRD) || (state == S_UPD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      grad_ok <= '0;
      wm_ok <= '0;
      ra <= '0;
      cnt <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          ra <= '0;
          cnt <= '0;
          if (acc_in) begin
            priority if (in_action == lnu_pkg::ACT_LOAD) begin
              if (CW'(in_index) < used_count) begin
                row_mem[in_index[AW-1:0]] <= in_feature;
                if (CW'(in_index) == used_count - CW'(1)) begin
                  acc <= '0;
                  state <= S_DOT;
                end
              end
            end else if (in_action == lnu_pkg::ACT_UPDATE) begin
              eta <= in_eta;
              onem <= lnu_pkg::sat64(64'sd16777216 - 64'(in_eta));
              state <= S_UPD;
            end else if (in_action == lnu_pkg::ACT_CLEAR) begin
              grad_ok <= '0;
              wm_ok <= '0;
              state <= S_CLR;
            end else begin
            end
          end
        end
        // Stream row and momentum; multiply-accumulate one entry per cycle.
        S_DOT: begin
          if (rd_en) acc <= acc + lnu_pkg::qmul_wide(m_val, row_q);
          if (cnt == used_count - CW'(1)) state <= S_DOTW;
          else begin
            cnt <= cnt + CW'(1);
            ra <= ra + AW'(1);
          end
        end
        S_DOTW: begin
          ip <= lnu_pkg::sat64(acc + lnu_pkg::qmul_wide(m_val, row_q));
          state <= S_P1;
        end
        S_P1: begin m_a <= ip; m_b <= ip; state <= S_P2; end
        S_P2: begin t2 <= lnu_pkg::sat64(m_wide); state <= S_P3; end
        S_P3: begin m_a <= t2; m_b <= ip; tmp <= lnu_pkg::qmul(coef_one, ip);
          state <= S_P4; end
        S_P4: begin t2 <= lnu_pkg::sat64(m_wide);
          tmp <= lnu_pkg::qadd(coef_zero, tmp); state <= S_P5; end
        S_P5: begin m_a <= gamma_scale;
          m_b <= lnu_pkg::qadd(tmp, lnu_pkg::qmul(coef_three, t2));
          state <= S_P6; end
        S_P6: begin
          tmp <= lnu_pkg::sat64(m_wide);
          ra <= '0; cnt <= '0;
          state <= S_GRD;
        end
        // Gradient pass: read row and gradient, write the sum back.
        S_GRD: begin
          if (rd_en) begin
            grad_mem[la] <= lnu_pkg::qadd(grad_val, lnu_pkg::qmul(tmp, row_q));
            grad_ok[la] <= 1'b1;
          end
          if (cnt == used_count) state <= S_IDLE;
          else begin
            cnt <= cnt + CW'(1);
            if (cnt != used_count - CW'(1)) ra <= ra + AW'(1);
          end
        end
        S_UPD: state <= S_UPD2;
        S_UPD2: begin
          t1 <= lnu_pkg::qadd(m_val, grad_val);
          t2u <= lnu_pkg::qmul(eta, w_val);
          state <= S_UPD3;
        end
        S_UPD3: begin
          wm_mem[la] <= {t1, lnu_pkg::qadd(lnu_pkg::qmul(t1, onem), t2u)};
          wm_ok[la] <= 1'b1;
          grad_ok[la] <= 1'b0;
          out_valid <= 1'b1;
          out_index <= 6'(la);
          out_weight <= t1;
          out_last <= (cnt == used_count - CW'(1));
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (cnt == used_count - CW'(1)) begin
              grad_ok <= '0;
              state <= S_IDLE;
            end else begin
              cnt <= cnt + CW'(1);
              ra <= ra + AW'(1);
              state <= S_UPD;
            end
          end
        end
        S_CLR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `LNU_ASSERT_IMP(a_no_accept_busy, clk, rst, in_valid && in_ready, state == S_IDLE,
    "item accepted while engine busy")
  `LNU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid,
    "result dropped while stalled")
  `LNU_ASSERT_IMP(a_out_state, clk, rst, out_valid, state == S_OUT || state == S_IDLE,
    "result shown outside output step")
endmodule

// ===== rtl/logistic_nesterov_update_core.sv =====
// Top level of the logistic regression Nesterov update core.
// A load item writes its feature into the row store; the last feature of a row
// then runs the dot pass, the cubic and the gradient pass.
// An update emits one weight at a time and holds each while the beat waits.
// Throughput is one item at a time: input is taken only while the engine is idle.
// Synchronous reset clears control state and marks gradient and weight/momentum as zero.
`timescale 1ns / 1ps
module logistic_nesterov_update_core #(
  parameter int MAX_FEATURES = lnu_pkg::MAX_FEATURES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lnu_if.sink         in_ch,
  lnu_if.source       out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // Configuration registers feed the engine directly; the user must write them only
  // while the engine is idle, as the block itself does not enforce it.
  lnu_pkg::q_t gamma_scale, coef_zero, coef_one, coef_three;
  logic [$clog2(MAX_FEATURES+1)-1:0] used_count;

  lnu_regs #(.MAX_FEATURES(MAX_FEATURES)) u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .gamma_scale, .coef_zero, .coef_one, .coef_three, .used_count
  );

  // The engine owns the row, gradient and weight/momentum memories.
  lnu_engine #(.MAX_FEATURES(MAX_FEATURES)) u_engine (
    .clk, .rst,
    .gamma_scale, .coef_zero, .coef_one, .coef_three, .used_count,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_action(in_ch.data.action), .in_index(in_ch.data.feature_index),
    .in_feature(in_ch.data.feature_value), .in_eta(in_ch.data.eta_value),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_index(out_ch.data.weight_index), .out_weight(out_ch.data.weight_value),
    .out_last(out_ch.data.last)
  );
endmodule
